// ===== hw/rtl/kmst_pkg.sv =====
package kmst_pkg;

	localparam int MaxEdges = 64;
	localparam int MaxVertices = 32;
	localparam int WeightBits = 16;
	localparam int VtxW = 6;
	localparam int EdgeIdxW = $clog2(MaxEdges);
	localparam int EdgeCntW = $clog2(MaxEdges + 1);
	localparam int VIdxW = $clog2(MaxVertices);
	localparam int RankW = 5;
	localparam int StepW = $clog2(MaxVertices + 1);
	localparam logic [VtxW-1:0] VcReset = VtxW'(20);

	typedef struct packed {
		logic [VtxW-1:0] from_v;
		logic [VtxW-1:0] to_v;
		logic [WeightBits-1:0] weight;
	} edge_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_edge;
		logic clear_store;
		logic forest_init;
		logic forest_step;
		logic sel_start;
		logic sel_step;
		logic sel_take;
		logic find_a_init;
		logic find_b_init;
		logic find_step_a;
		logic find_step_b;
		logic do_join;
		logic out_load_edge;
		logic out_load_empty;
		logic out_mark_last;
	} kmst_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic init_done;
		logic sel_done;
		logic sel_none;
		logic edge_in_range;
		logic find_a_done;
		logic find_b_done;
		logic same_root;
		logic tree_full;
		logic any_out;
	} kmst_sts_t;

	// true if a sorts before b on weight, from, to
	function automatic logic key_less(edge_t a, edge_t b);
		if (a.weight != b.weight) return a.weight < b.weight;
		if (a.from_v != b.from_v) return a.from_v < b.from_v;
		return a.to_v < b.to_v;
	endfunction

endpackage

// ===== hw/rtl/kmst_if.sv =====
interface kmst_edge_if;
	logic valid;
	logic ready;
	logic [5:0] from_vertex;
	logic [5:0] to_vertex;
	logic [15:0] edge_weight;
	logic final_edge;
	modport source (output valid, from_vertex, to_vertex, edge_weight, final_edge, input ready);
	modport sink (input valid, from_vertex, to_vertex, edge_weight, final_edge, output ready);
endinterface

interface kmst_tree_if;
	logic valid;
	logic ready;
	logic [5:0] tree_from;
	logic [5:0] tree_to;
	logic [15:0] tree_weight;
	logic edge_valid;
	logic last_of_tree;
	logic spanning;
	logic overflow;
	modport source (output valid, tree_from, tree_to, tree_weight, edge_valid, last_of_tree,
		spanning, overflow, input ready);
	modport sink (input valid, tree_from, tree_to, tree_weight, edge_valid, last_of_tree,
		spanning, overflow, output ready);
endinterface

interface kmst_cfg_if;
	logic valid;
	logic ready;
	logic [5:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/kmst_datapath.sv =====
module kmst_datapath (
	input  logic clk,
	input  logic arst_n,
	input  kmst_pkg::kmst_cmd_t cmd,
	output kmst_pkg::kmst_sts_t sts,
	input  logic [5:0] in_from,
	input  logic [5:0] in_to,
	input  logic [15:0] in_weight,
	input  logic [5:0] vc_raw,
	output logic [5:0] out_from,
	output logic [5:0] out_to,
	output logic [15:0] out_weight,
	output logic out_edge_valid,
	output logic out_spanning,
	output logic out_overflow
);
	localparam int EW = kmst_pkg::EdgeIdxW;
	localparam int CW = kmst_pkg::EdgeCntW;
	localparam int VW = kmst_pkg::VIdxW;
	localparam int XW = kmst_pkg::VtxW;
	localparam int RW = kmst_pkg::RankW;
	localparam int SW = kmst_pkg::StepW;

	// edge store, used flags per entry for selection sort
	kmst_pkg::edge_t store_mem [kmst_pkg::MaxEdges];
	logic [kmst_pkg::MaxEdges-1:0] used_q;
	logic [CW-1:0] edge_total_q;
	logic dropped_q;

	logic in_ok;
	assign in_ok = (in_from != in_to) && (in_from != '0) && (in_to != '0)
		&& ({1'b0, in_from} <= (XW+1)'(kmst_pkg::MaxVertices))
		&& ({1'b0, in_to} <= (XW+1)'(kmst_pkg::MaxVertices));

	always_ff @(posedge clk) begin
		if (cmd.load_edge && in_ok && edge_total_q < CW'(kmst_pkg::MaxEdges))
			store_mem[edge_total_q[EW-1:0]] <= '{in_from, in_to,
				kmst_pkg::WeightBits'(in_weight)};
	end

	// scan pointer and registered read
	logic [CW-1:0] scan_q;
	logic [EW-1:0] best_idx_q;
	logic best_found_q;
	kmst_pkg::edge_t best_q;
	kmst_pkg::edge_t rd_q;
	logic [EW-1:0] rd_idx_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		rd_q <= store_mem[scan_q[EW-1:0]];
		rd_idx_q <= scan_q[EW-1:0];
	end

	// vertex count clamp
	logic [XW-1:0] vc;
	always_comb begin
		vc = vc_raw;
		if (vc == '0) vc = XW'(1);
		if (vc > XW'(kmst_pkg::MaxVertices)) vc = XW'(kmst_pkg::MaxVertices);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			dropped_q <= 1'b0;
			used_q <= '0;
			scan_q <= '0;
			rd_vld_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (cmd.clear_store) begin
				edge_total_q <= '0;
				dropped_q <= 1'b0;
				used_q <= '0;
			end else if (cmd.load_edge && in_ok) begin
				if (edge_total_q < CW'(kmst_pkg::MaxEdges)) edge_total_q <= edge_total_q + 1'b1;
				else dropped_q <= 1'b1;
			end
			if (cmd.sel_start) begin
				scan_q <= '0;
				rd_vld_q <= 1'b0;
				best_found_q <= 1'b0;
			end else if (cmd.sel_step) begin
				rd_vld_q <= scan_q < edge_total_q;
				if (scan_q < edge_total_q) scan_q <= scan_q + 1'b1;
				// keep earliest minimum: strict less keeps arrival order
				if (rd_vld_q && !used_q[rd_idx_q]
					&& (!best_found_q || kmst_pkg::key_less(rd_q, best_q))) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.sel_take) used_q[best_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_step && rd_vld_q && !used_q[rd_idx_q]
			&& (!best_found_q || kmst_pkg::key_less(rd_q, best_q))) begin
			best_q <= rd_q;
			best_idx_q <= rd_idx_q;
		end
	end

	assign sts.sel_done = !rd_vld_q && (scan_q == edge_total_q);
	assign sts.sel_none = !best_found_q;
	assign sts.edge_in_range = (best_q.from_v <= vc) && (best_q.to_v <= vc);

	// union-find forest in a small memory, one access per cycle
	logic [XW-1:0] parent_mem [kmst_pkg::MaxVertices];
	logic [RW-1:0] rank_mem [kmst_pkg::MaxVertices];
	logic [SW-1:0] init_q;
	logic [XW-1:0] cur_q;
	logic [XW-1:0] cur_d;
	logic [XW-1:0] root_a_q;
	logic [XW-1:0] root_b_q;
	logic [RW-1:0] rank_a_q;
	logic [RW-1:0] rank_b_q;
	logic [XW-1:0] par_rd_q;
	logic [RW-1:0] rank_rd_q;
	logic [XW-1:0] tree_cnt_q;
	logic any_q;

	always_ff @(posedge clk) begin
		if (cmd.forest_init) begin
			parent_mem[init_q[VW-1:0]] <= XW'(init_q) + 1'b1;
			rank_mem[init_q[VW-1:0]] <= '0;
		end else if (cmd.do_join) begin
			if (rank_a_q == rank_b_q) begin
				parent_mem[VW'(root_b_q - 1'b1)] <= root_a_q;
				rank_mem[VW'(root_a_q - 1'b1)] <= rank_a_q + 1'b1;
			end else if (rank_b_q < rank_a_q) begin
				parent_mem[VW'(root_b_q - 1'b1)] <= root_a_q;
			end else begin
				parent_mem[VW'(root_a_q - 1'b1)] <= root_b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			tree_cnt_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (cmd.forest_step) init_q <= '0;
			else if (cmd.forest_init) init_q <= init_q + 1'b1;
			if (cmd.forest_step) begin
				tree_cnt_q <= '0;
				any_q <= 1'b0;
			end else if (cmd.do_join) begin
				tree_cnt_q <= tree_cnt_q + 1'b1;
				any_q <= 1'b1;
			end
		end
	end

	// next walk position, read from the forest in the same edge
	always_comb begin
		cur_d = cur_q;
		if (cmd.find_a_init) cur_d = best_q.from_v;
		else if (cmd.find_b_init) cur_d = best_q.to_v;
		else if (cmd.find_step_a || cmd.find_step_b) cur_d = par_rd_q;
	end

	// root walk, one parent hop a cycle
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		par_rd_q <= parent_mem[VW'(cur_d - 1'b1)];
		rank_rd_q <= rank_mem[VW'(cur_d - 1'b1)];
		if (cmd.find_step_a) begin
			root_a_q <= cur_q;
			rank_a_q <= rank_rd_q;
		end
		if (cmd.find_step_b) begin
			root_b_q <= cur_q;
			rank_b_q <= rank_rd_q;
		end
	end

	assign sts.init_done = init_q == SW'(kmst_pkg::MaxVertices - 1);
	assign sts.find_a_done = par_rd_q == cur_q;
	assign sts.find_b_done = par_rd_q == cur_q;
	assign sts.same_root = root_a_q == root_b_q;
	assign sts.tree_full = tree_cnt_q == vc - 1'b1;
	assign sts.any_out = any_q;

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load_edge) begin
			out_from <= best_q.from_v;
			out_to <= best_q.to_v;
			out_weight <= 16'(best_q.weight);
			out_edge_valid <= 1'b1;
			out_spanning <= 1'b0;
			out_overflow <= 1'b0;
		end else if (cmd.out_load_empty) begin
			out_from <= '0;
			out_to <= '0;
			out_weight <= '0;
			out_edge_valid <= 1'b0;
			out_spanning <= tree_cnt_q == vc - 1'b1;
			out_overflow <= dropped_q;
		end else if (cmd.out_mark_last) begin
			out_spanning <= tree_cnt_q == vc - 1'b1;
			out_overflow <= dropped_q;
		end
	end

endmodule

// ===== hw/rtl/kmst_ctrl.sv =====
module kmst_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_final,
	output logic in_ready,
	output logic out_valid,
	output logic out_last,
	input  logic out_ready,
	input  kmst_pkg::kmst_sts_t sts,
	output kmst_pkg::kmst_cmd_t cmd
);
	typedef enum logic [8:0] {
		S_LOAD   = 9'b000000001,
		S_INIT   = 9'b000000010,
		S_SCAN   = 9'b000000100,
		S_PICK   = 9'b000001000,
		S_FINDA  = 9'b000010000,
		S_FINDB  = 9'b000100000,
		S_JOIN   = 9'b001000000,
		S_EMIT   = 9'b010000000,
		S_LAST   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic ov_q, ov_d, last_q, last_d;
	// held edge waiting for a later result to reveal whether it is last
	logic pend_q, pend_d;

	assign in_ready = state_q == S_LOAD;
	assign out_valid = ov_q;
	assign out_last = last_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q;
		last_d = last_q;
		pend_d = pend_q;
		cmd = '0;
		if (ov_q && out_ready) ov_d = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load_edge = in_fire;
				if (in_fire && in_final) begin
					cmd.forest_step = 1'b1;
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.forest_init = 1'b1;
				if (sts.init_done) begin
					cmd.sel_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.sel_step = 1'b1;
				if (sts.sel_done) state_d = S_PICK;
			end
			S_PICK: begin
				if (sts.sel_none || sts.tree_full) begin
					state_d = S_LAST;
				end else begin
					cmd.sel_take = 1'b1;
					if (sts.edge_in_range) begin
						cmd.find_a_init = 1'b1;
						state_d = S_FINDA;
					end else begin
						cmd.sel_start = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_FINDA: begin
				cmd.find_step_a = 1'b1;
				if (sts.find_a_done) begin
					cmd.find_b_init = 1'b1;
					state_d = S_FINDB;
				end
			end
			S_FINDB: begin
				cmd.find_step_b = 1'b1;
				if (sts.find_b_done) state_d = S_JOIN;
			end
			S_JOIN: begin
				if (sts.same_root) begin
					cmd.sel_start = 1'b1;
					state_d = S_SCAN;
				end else if (ov_q ? out_ready : !pend_q) begin
					// output register free: the new edge replaces it, held back
					cmd.do_join = 1'b1;
					cmd.out_load_edge = 1'b1;
					pend_d = 1'b1;
					state_d = S_EMIT;
				end else if (!ov_q) begin
					// another edge follows, so the held one is not last
					ov_d = 1'b1;
					last_d = 1'b0;
				end
			end
			S_EMIT: begin
				// hold the taken edge until the next one or the end of the run
				cmd.sel_start = 1'b1;
				state_d = S_SCAN;
			end
			S_LAST: begin
				if (!ov_d) begin
					if (sts.any_out) cmd.out_mark_last = 1'b1;
					else cmd.out_load_empty = 1'b1;
					cmd.clear_store = 1'b1;
					ov_d = 1'b1;
					last_d = 1'b1;
					pend_d = 1'b0;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ov_q <= 1'b0;
			last_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			last_q <= last_d;
			pend_q <= pend_d;
		end
	end

endmodule

// ===== hw/rtl/kruskal_minimum_spanning_tree.sv =====
// Kruskal minimum spanning tree with union-find.
// edges: one item per cycle while loading; the item with final_edge set is
//   stored and starts the run, during which edges is not ready.
// cfg: writes vertex_count (reset 20); the user must write it only while idle, the block does not enforce it.
// tree: one item per spanning-tree edge in ascending key order, the final
//   one carrying last_of_tree, spanning and overflow. With no tree edge a
//   single item with edge_valid low is sent.
// Run: a forest clear, then one pass over the store per pick. A taken edge
//   adds a walk to the root of each end and a join, an edge whose ends share
//   a root the walks alone; the run ends with a final pass over the store.
// A tree edge stays in the output register until the next one is taken or
//   the run ends, and only then is sent; a stalled receiver pauses the run
//   when the next tree edge or the end of the run is reached.
// Reset clears the store, counters and output valid; the forest is rebuilt
//   at the start of every run.
module kruskal_minimum_spanning_tree (
	input logic clk,
	input logic arst_n,
	kmst_edge_if.sink edges,
	kmst_tree_if.source tree,
	kmst_cfg_if.sink cfg
);
	kmst_pkg::kmst_cmd_t cmd;
	kmst_pkg::kmst_sts_t sts;
	logic [5:0] vc_q;
	logic out_last;

	// vertex count register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= kmst_pkg::VcReset;
		else if (cfg.valid) vc_q <= cfg.data;
	end

	kmst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(edges.valid && edges.ready), .in_final(edges.final_edge),
		.in_ready(edges.ready),
		.out_valid(tree.valid), .out_last(out_last), .out_ready(tree.ready),
		.sts(sts), .cmd(cmd)
	);

	kmst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_from(edges.from_vertex), .in_to(edges.to_vertex),
		.in_weight(edges.edge_weight), .vc_raw(vc_q),
		.out_from(tree.tree_from), .out_to(tree.tree_to),
		.out_weight(tree.tree_weight), .out_edge_valid(tree.edge_valid),
		.out_spanning(tree.spanning), .out_overflow(tree.overflow)
	);

	assign tree.last_of_tree = out_last;

`ifndef SYNTHESIS
	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		edges.ready |-> !tree.valid || tree.last_of_tree)
		else $error("edge input open while a tree edge is out");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tree.valid && !tree.ready |=> tree.valid)
		else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		tree.valid && !tree.ready |=> $stable({tree.tree_from, tree.tree_to,
		tree.tree_weight, tree.edge_valid, tree.last_of_tree, tree.spanning,
		tree.overflow}))
		else $error("result changed while stalled");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tree.valid && !tree.edge_valid |-> tree.last_of_tree)
		else $error("empty result not marked last");
`endif

endmodule

// ===== tb/tb_if.sv =====
`timescale 1ns / 1ps

// the block's interfaces live with the RTL; this file carries helper
// record types shared by the testbench
package tb_kmst_pkg;
	typedef struct packed {
		logic [5:0] from_vertex;
		logic [5:0] to_vertex;
		logic [15:0] edge_weight;
		logic final_edge;
	} edge_item_t;

	typedef struct packed {
		logic [5:0] tree_from;
		logic [5:0] tree_to;
		logic [15:0] tree_weight;
		logic edge_valid;
		logic last_of_tree;
		logic spanning;
		logic overflow;
	} tree_item_t;
endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int CycleLimit = 3000000;

	logic clk;
	logic arst_n;

	kmst_edge_if edges ();
	kmst_tree_if tree ();
	kmst_cfg_if cfg ();

	kruskal_minimum_spanning_tree DUT (
		.clk(clk),
		.arst_n(arst_n),
		.edges(edges.sink),
		.tree(tree.source),
		.cfg(cfg.sink)
	);

	// predictor state
	logic [5:0] vc_shadow;
	logic [5:0] graph_from[$];
	logic [5:0] graph_to[$];
	logic [15:0] graph_weight[$];
	logic graph_dropped;
	tb_kmst_pkg::tree_item_t tree_expected[$];

	tb_kmst_pkg::edge_item_t pending_edges[$];
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	int fail_count;
	longint cycle_count;

	// kruskal over the stored graph, pushing the expected tree items
	function automatic void predict_tree();
		int vc, need, n, taken, k, e, t, a, b, p, q;
		int order[$];
		logic [5:0] parent[1:32];
		logic [4:0] rnk[1:32];
		tb_kmst_pkg::tree_item_t r;
		vc = vc_shadow;
		if (vc == 0) vc = 1;
		if (vc > kmst_pkg::MaxVertices) vc = kmst_pkg::MaxVertices;
		need = vc - 1;
		for (int v = 1; v <= 32; v++) begin
			parent[v] = 6'(v);
			rnk[v] = '0;
		end
		n = graph_from.size();
		for (int i = 0; i < n; i++) begin
			k = order.size();
			while (k > 0) begin
				t = order[k-1];
				if (graph_weight[i] < graph_weight[t] || (graph_weight[i] == graph_weight[t] &&
					(graph_from[i] < graph_from[t] || (graph_from[i] == graph_from[t] &&
					graph_to[i] < graph_to[t]))))
					k--;
				else
					break;
			end
			order.insert(k, i);
		end
		taken = 0;
		for (int i = 0; i < n && taken < need; i++) begin
			e = order[i];
			a = graph_from[e];
			b = graph_to[e];
			if (a > vc || b > vc) continue;
			p = a;
			while (parent[p] != p) p = parent[p];
			q = b;
			while (parent[q] != q) q = parent[q];
			if (p == q) continue;
			if (rnk[p] == rnk[q]) begin
				parent[q] = 6'(p);
				rnk[p] = 5'(rnk[p] + 1);
			end else if (rnk[q] < rnk[p]) begin
				parent[q] = 6'(p);
			end else begin
				parent[p] = 6'(q);
			end
			taken++;
			r.tree_from = 6'(a);
			r.tree_to = 6'(b);
			r.tree_weight = graph_weight[e];
			r.edge_valid = 1'b1;
			r.last_of_tree = 1'b0;
			r.spanning = 1'b0;
			r.overflow = 1'b0;
			tree_expected.push_back(r);
		end
		if (taken == 0) begin
			r.tree_from = '0;
			r.tree_to = '0;
			r.tree_weight = '0;
			r.edge_valid = 1'b0;
			r.last_of_tree = 1'b0;
			r.spanning = 1'b0;
			r.overflow = 1'b0;
			tree_expected.push_back(r);
		end
		r = tree_expected[$];
		r.last_of_tree = 1'b1;
		r.spanning = (taken == need);
		r.overflow = graph_dropped;
		tree_expected[tree_expected.size()-1] = r;
		graph_from.delete();
		graph_to.delete();
		graph_weight.delete();
		graph_dropped = 1'b0;
	endfunction

	// store an accepted edge and run the tree on the final one
	function automatic void predict_edge(tb_kmst_pkg::edge_item_t it);
		if (it.from_vertex != it.to_vertex && it.from_vertex >= 1 &&
			it.from_vertex <= kmst_pkg::MaxVertices && it.to_vertex >= 1 &&
			it.to_vertex <= kmst_pkg::MaxVertices) begin
			if (graph_from.size() < kmst_pkg::MaxEdges) begin
				graph_from.push_back(it.from_vertex);
				graph_to.push_back(it.to_vertex);
				graph_weight.push_back(it.edge_weight);
			end else begin
				graph_dropped = 1'b1;
			end
		end
		if (it.final_edge) predict_tree();
	endfunction

	function automatic tb_kmst_pkg::edge_item_t make_edge(int f, int t, int w, bit fin);
		tb_kmst_pkg::edge_item_t it;
		it.from_vertex = 6'(f);
		it.to_vertex = 6'(t);
		it.edge_weight = 16'(w);
		it.final_edge = fin;
		return it;
	endfunction

	// random graph over vertices 1..vc with mostly in-range edges
	task automatic queue_graph(int vc, int count, int wmax);
		int f, t;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0: begin
					f = $urandom_range(0, 63);
					t = $urandom_range(0, 63);
				end
				1: begin
					f = $urandom_range(1, 32);
					t = f;
				end
				2: begin
					f = $urandom_range(1, 32);
					t = $urandom_range(1, 32);
				end
				default: begin
					f = $urandom_range(1, vc);
					t = $urandom_range(1, vc);
				end
			endcase
			pending_edges.push_back(make_edge(f, t, $urandom_range(0, wmax), i == count - 1));
		end
	endtask

	task automatic write_vertex_count(int value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= 6'(value);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		vc_shadow = 6'(value);
	endtask

	task automatic wait_drained();
		while (pending_edges.size() != 0 || edges.valid || tree_expected.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// edge driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges.valid <= 1'b0;
			edges.from_vertex <= '0;
			edges.to_vertex <= '0;
			edges.edge_weight <= '0;
			edges.final_edge <= 1'b0;
		end else begin
			if (edges.valid && edges.ready) begin
				predict_edge(make_edge(edges.from_vertex, edges.to_vertex,
					edges.edge_weight, edges.final_edge));
			end
			if (!edges.valid || edges.ready) begin
				if (pending_edges.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					tb_kmst_pkg::edge_item_t it;
					it = pending_edges.pop_front();
					edges.valid <= 1'b1;
					edges.from_vertex <= it.from_vertex;
					edges.to_vertex <= it.to_vertex;
					edges.edge_weight <= it.edge_weight;
					edges.final_edge <= it.final_edge;
				end else begin
					edges.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree.ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			tree.ready <= 1'b0;
		end else begin
			tree.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// tree monitor and checker
	always @(posedge clk) begin
		if (arst_n && tree.valid && tree.ready) begin
			tb_kmst_pkg::tree_item_t got, want;
			got.tree_from = tree.tree_from;
			got.tree_to = tree.tree_to;
			got.tree_weight = tree.tree_weight;
			got.edge_valid = tree.edge_valid;
			got.last_of_tree = tree.last_of_tree;
			got.spanning = tree.spanning;
			got.overflow = tree.overflow;
			if (tree_expected.size() == 0) begin
				$display("%0t: unexpected tree item from=%0d to=%0d w=%0d", $time,
					got.tree_from, got.tree_to, got.tree_weight);
				fail_count++;
			end else begin
				want = tree_expected.pop_front();
				if (got !== want) begin
					$display({"%0t: tree item mismatch expected from=%0d to=%0d w=%0d",
						" ev=%0b last=%0b sp=%0b ov=%0b"},
						$time, want.tree_from, want.tree_to, want.tree_weight, want.edge_valid,
						want.last_of_tree, want.spanning, want.overflow);
					$display({"%0t:                    actual from=%0d to=%0d w=%0d",
						" ev=%0b last=%0b sp=%0b ov=%0b"},
						$time, got.tree_from, got.tree_to, got.tree_weight, got.edge_valid,
						got.last_of_tree, got.spanning, got.overflow);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("kruskal_minimum_spanning_tree verification failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		int vcs[4];
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		fail_count = 0;
		cycle_count = 0;
		vc_shadow = 6'(20);
		graph_dropped = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset vertex count, extremes, ties, self-loop, bad endpoints
		pending_edges.push_back(make_edge(1, 2, 65535, 0));
		pending_edges.push_back(make_edge(2, 3, 0, 0));
		pending_edges.push_back(make_edge(3, 1, 0, 0));
		pending_edges.push_back(make_edge(3, 2, 0, 0));
		pending_edges.push_back(make_edge(5, 5, 7, 0));
		pending_edges.push_back(make_edge(0, 4, 7, 0));
		pending_edges.push_back(make_edge(4, 33, 7, 0));
		pending_edges.push_back(make_edge(63, 62, 7, 0));
		pending_edges.push_back(make_edge(32, 21, 1, 0));
		pending_edges.push_back(make_edge(4, 20, 43690, 0));
		pending_edges.push_back(make_edge(20, 4, 21845, 1));
		// empty graph: single item with edge_valid low
		pending_edges.push_back(make_edge(9, 9, 3, 1));
		wait_drained();

		// vertex count 1: nothing needed, trivially spanning
		write_vertex_count(1);
		pending_edges.push_back(make_edge(1, 2, 5, 1));
		wait_drained();
		write_vertex_count(0);
		pending_edges.push_back(make_edge(1, 2, 5, 1));
		wait_drained();

		// overflow with the receiver held off while the next graph waits
		write_vertex_count(32);
		hold_off_cycles = 3000;
		queue_graph(32, 85, 65535);
		queue_graph(32, 10, 65535);
		wait_drained();
		write_vertex_count(63);
		queue_graph(32, 30, 15);
		wait_drained();

		// random phases over several vertex counts and idling profiles
		vcs = '{2, 8, 32, 17};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 83; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 83; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			write_vertex_count(vcs[ph]);
			for (int g = 0; g < 5; g++)
				queue_graph(vcs[ph], $urandom_range(1, 20), (g % 2) ? 7 : 65535);
			wait_drained();
		end

		if (fail_count == 0)
			$display("kruskal_minimum_spanning_tree verification clean");
		else
			$display("kruskal_minimum_spanning_tree verification failed");
		$finish;
	end

endmodule
